>>> rtl/affine_backward_warp_defines.svh
// Assertion macros used by the checker file of the affine backward warp.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef AFFINE_BACKWARD_WARP_DEFINES_SVH
`define AFFINE_BACKWARD_WARP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ABW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/abw_pkg.sv
// Shared types and constants of the affine backward warp.
// No dependencies; used by the interfaces, the frame store, the top level and the checker.
`default_nettype none

package abw_pkg;

	localparam int DEF_MAX_ROWS       = 256;
	localparam int DEF_MAX_COLS       = 256;
	localparam int DEF_COEF_FRAC_BITS = 16;

	localparam int COEF_W    = 32;
	localparam int PIX_W     = 8;
	localparam int COORD_W   = 8;
	localparam int SIZE_W    = 9;
	localparam int CFG_IDX_W = 3;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_MAP  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_Y_FROM_Y = 3'd0,
		CFG_COEF_Y_FROM_X = 3'd1,
		CFG_OFFSET_Y      = 3'd2,
		CFG_COEF_X_FROM_Y = 3'd3,
		CFG_COEF_X_FROM_X = 3'd4,
		CFG_OFFSET_X      = 3'd5,
		CFG_FRAME_ROWS    = 3'd6,
		CFG_FRAME_COLS    = 3'd7
	} cfg_reg_t;

	// Frame store access strobes.
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/abw_if.sv
// Valid/ready channel interfaces for requests and responses of the warp.
// Depends on abw_pkg for field widths.
`default_nettype none

interface abw_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [abw_pkg::COORD_W-1:0] row;
	logic [abw_pkg::COORD_W-1:0] col;
	logic [abw_pkg::PIX_W-1:0]   pixel_in;

	modport source (output valid, req_type, row, col, pixel_in, input ready);
	modport sink   (input valid, req_type, row, col, pixel_in, output ready);
endinterface

interface abw_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [abw_pkg::PIX_W-1:0] pixel_out;
	logic                      in_range;

	modport source (output valid, pixel_out, in_range, input ready);
	modport sink   (input valid, pixel_out, in_range, output ready);
endinterface

`default_nettype wire

>>> rtl/abw_frame_store.sv
// Single-port frame store with registered read data.
// Depends on abw_pkg for the access strobe struct.
`default_nettype none

module abw_frame_store #(
	parameter int DEPTH  = abw_pkg::DEF_MAX_ROWS * abw_pkg::DEF_MAX_COLS,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire                          clk,
	input  wire abw_pkg::mem_ctl_t       ctl,
	input  wire [ADDR_W-1:0]             addr,
	input  wire [abw_pkg::PIX_W-1:0]     wdata,
	output logic [abw_pkg::PIX_W-1:0]    rdata
);

	logic [abw_pkg::PIX_W-1:0] mem [DEPTH];

	// Write wins; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end else if (ctl.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/affine_backward_warp.sv
// Affine backward warp, top level: config registers, coordinate pipeline, frame store.
// Depends on abw_pkg, abw_req_if / abw_rsp_if and abw_frame_store.
//
// Backward (inverse-mapping) affine warp of an 8-bit grayscale frame with
// nearest-pixel fetch. A load request (req_type 0) writes pixel_in at (row, col)
// of the frame store and gives no response; loads beyond MAX_ROWS x MAX_COLS are
// dropped. A map request (req_type 1) names an output position; the source
// position is coef * (row, col) + offset in fixed point with COEF_FRAC_BITS
// fraction bits, truncated toward zero, checked against frame_rows/frame_cols
// (clamped to MAX_ROWS/MAX_COLS), and answered with the stored pixel and
// in_range = 1, or pixel 0 and in_range = 0. Throughput is one request per
// clock while the output is not stalled, loads and maps freely mixed. The
// item passes four registers: input register, 32x8 products, three-term sums,
// then truncation, range check and the single frame store access, whose
// registered read data is the output register. The frame store port carries
// one load write or one map read per cycle. The store is not cleared at
// reset; fetching a never-loaded pixel returns an arbitrary value.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, which the block does not enforce.
`default_nettype none

module affine_backward_warp #(
	parameter int MAX_ROWS       = abw_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS       = abw_pkg::DEF_MAX_COLS,
	parameter int COEF_FRAC_BITS = abw_pkg::DEF_COEF_FRAC_BITS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	abw_req_if.sink                         req,
	abw_rsp_if.source                       rsp,
	input  wire                             cfg_we,
	input  wire [abw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [abw_pkg::COEF_W-1:0]       cfg_data
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PROD_W = abw_pkg::COEF_W + abw_pkg::COORD_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int Q_W    = SUM_W - COEF_FRAC_BITS;
	localparam logic [SUM_W-1:0] FRAC_MASK =
		{{(SUM_W-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};

	// ---- configuration registers ----
	logic signed [abw_pkg::COEF_W-1:0] coef_yy_q, coef_yx_q, off_y_q;
	logic signed [abw_pkg::COEF_W-1:0] coef_xy_q, coef_xx_q, off_x_q;
	logic [abw_pkg::SIZE_W-1:0]        frame_rows_q, frame_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_yy_q    <= 32'sd65536;
			coef_yx_q    <= '0;
			off_y_q      <= '0;
			coef_xy_q    <= '0;
			coef_xx_q    <= 32'sd65536;
			off_x_q      <= '0;
			frame_rows_q <= 9'd256;
			frame_cols_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (abw_pkg::cfg_reg_t'(cfg_index))
				abw_pkg::CFG_COEF_Y_FROM_Y: coef_yy_q <= cfg_data;
				abw_pkg::CFG_COEF_Y_FROM_X: coef_yx_q <= cfg_data;
				abw_pkg::CFG_OFFSET_Y:      off_y_q   <= cfg_data;
				abw_pkg::CFG_COEF_X_FROM_Y: coef_xy_q <= cfg_data;
				abw_pkg::CFG_COEF_X_FROM_X: coef_xx_q <= cfg_data;
				abw_pkg::CFG_OFFSET_X:      off_x_q   <= cfg_data;
				abw_pkg::CFG_FRAME_ROWS:    frame_rows_q <= cfg_data[abw_pkg::SIZE_W-1:0];
				abw_pkg::CFG_FRAME_COLS:    frame_cols_q <= cfg_data[abw_pkg::SIZE_W-1:0];
			endcase
		end
	end

	// Frame size in use, clamped to the store size.
	logic [Q_W-1:0] rows_lim, cols_lim;
	assign rows_lim = (int'(frame_rows_q) > MAX_ROWS) ? Q_W'(MAX_ROWS) : Q_W'(frame_rows_q);
	assign cols_lim = (int'(frame_cols_q) > MAX_COLS) ? Q_W'(MAX_COLS) : Q_W'(frame_cols_q);

	// ---- stage enables: a stage moves when empty or when the next one moves ----
	logic v1_q, v2_q, v3_q, v4_q;
	logic en1, en2, en3, en4;

	assign en4 = !v4_q || rsp.ready;
	assign en3 = !v3_q || en4;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign req.ready = en1;

	// ---- stage 1: input register ----
	logic                        map_s1;
	logic [abw_pkg::COORD_W-1:0] row_s1, col_s1;
	logic [abw_pkg::PIX_W-1:0]   pix_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			map_s1 <= req.req_type;
			row_s1 <= req.row;
			col_s1 <= req.col;
			pix_s1 <= req.pixel_in;
		end
	end

	// ---- stage 2: products ----
	logic                        map_s2;
	logic [abw_pkg::COORD_W-1:0] row_s2, col_s2;
	logic [abw_pkg::PIX_W-1:0]   pix_s2;
	logic signed [PROD_W-1:0]    p_yy_s2, p_yx_s2, p_xy_s2, p_xx_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			map_s2  <= map_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			pix_s2  <= pix_s1;
			p_yy_s2 <= coef_yy_q * $signed({1'b0, row_s1});
			p_yx_s2 <= coef_yx_q * $signed({1'b0, col_s1});
			p_xy_s2 <= coef_xy_q * $signed({1'b0, row_s1});
			p_xx_s2 <= coef_xx_q * $signed({1'b0, col_s1});
		end
	end

	// ---- stage 3: fixed-point source position ----
	logic                        map_s3;
	logic [abw_pkg::COORD_W-1:0] row_s3, col_s3;
	logic [abw_pkg::PIX_W-1:0]   pix_s3;
	logic signed [SUM_W-1:0]     sy_s3, sx_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			map_s3 <= map_s2;
			row_s3 <= row_s2;
			col_s3 <= col_s2;
			pix_s3 <= pix_s2;
			sy_s3  <= SUM_W'(p_yy_s2) + SUM_W'(p_yx_s2) + SUM_W'(off_y_q);
			sx_s3  <= SUM_W'(p_xy_s2) + SUM_W'(p_xx_s2) + SUM_W'(off_x_q);
		end
	end

	// ---- stage valid bits ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (en1) v1_q <= req.valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			// loads retire in stage 3; only maps reach the output
			if (en4) v4_q <= v3_q && (map_s3 == abw_pkg::REQ_MAP);
		end
	end

	// Truncate toward zero: negative values get the fraction mask added first.
	logic [SUM_W-1:0]     sy_bias, sx_bias;
	logic signed [Q_W-1:0] qy, qx;
	logic                  map_ok;

	assign sy_bias = sy_s3 + (sy_s3[SUM_W-1] ? FRAC_MASK : '0);
	assign sx_bias = sx_s3 + (sx_s3[SUM_W-1] ? FRAC_MASK : '0);
	assign qy      = sy_bias[SUM_W-1:COEF_FRAC_BITS];
	assign qx      = sx_bias[SUM_W-1:COEF_FRAC_BITS];
	assign map_ok  = !qy[Q_W-1] && !qx[Q_W-1] &&
	                 ($unsigned(qy) < rows_lim) && ($unsigned(qx) < cols_lim);

	logic load_ok;
	assign load_ok = (int'(row_s3) < MAX_ROWS) && (int'(col_s3) < MAX_COLS);

	// One shared address: map position or load position.
	logic [ADDR_W-1:0] addr_row, addr_col, mem_addr;
	assign addr_row = (map_s3 == abw_pkg::REQ_MAP) ? ADDR_W'(qy) : ADDR_W'(row_s3);
	assign addr_col = (map_s3 == abw_pkg::REQ_MAP) ? ADDR_W'(qx) : ADDR_W'(col_s3);
	assign mem_addr = addr_row * ADDR_W'(MAX_COLS) + addr_col;

	abw_pkg::mem_ctl_t mem_ctl;
	assign mem_ctl.wr = v3_q && en4 && (map_s3 == abw_pkg::REQ_LOAD) && load_ok;
	assign mem_ctl.rd = v3_q && en4 && (map_s3 == abw_pkg::REQ_MAP) && map_ok;

	logic [abw_pkg::PIX_W-1:0] rdata;

	abw_frame_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (pix_s3),
		.rdata (rdata)
	);

	// ---- stage 4: output register (store read data plus range flag) ----
	logic ok_s4;

	always_ff @(posedge clk) begin
		if (en4) ok_s4 <= map_ok;
	end

	assign rsp.valid     = v4_q;
	assign rsp.in_range  = ok_s4;
	assign rsp.pixel_out = ok_s4 ? rdata : '0;

endmodule

`default_nettype wire

>>> rtl/abw_checker.sv
// Port-level checker for the affine backward warp, bound to the top level.
// Depends on abw_pkg and the assertion macros in affine_backward_warp_defines.svh.
`default_nettype none
`include "affine_backward_warp_defines.svh"

module abw_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        req_valid,
	input wire                        req_ready,
	input wire                        req_type,
	input wire                        rsp_valid,
	input wire                        rsp_ready,
	input wire [abw_pkg::PIX_W-1:0]   pixel_out,
	input wire                        in_range
);

	// Maps accepted whose response is not yet transferred.
	logic [2:0] pending_q;
	logic       map_in, rsp_out;

	assign map_in  = req_valid && req_ready && (req_type == abw_pkg::REQ_MAP);
	assign rsp_out = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(map_in) - 3'(rsp_out);
		end
	end

	`ABW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(pixel_out) && $stable(in_range), "response changed while stalled")
	`ABW_ASSERT_NOW(a_oor_zero, rsp_valid && !in_range, pixel_out == '0, "out-of-range response with nonzero pixel")
	`ABW_ASSERT_NOW(a_no_orphan, rsp_valid, pending_q != 3'd0, "response without a pending map")
	`ABW_ASSERT_NOW(a_depth, 1'b1, pending_q <= 3'd4, "more maps in flight than pipeline stages")

endmodule

bind affine_backward_warp abw_checker u_abw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.req_type),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.pixel_out (rsp.pixel_out),
	.in_range  (rsp.in_range)
);

`default_nettype wire
